### sv/dnatbt_pkg.sv
// Shared types, codes and constants for the destination NAT rule table.
package dnatbt_pkg;

  localparam int DEF_ENTRIES = 64;
  localparam int ADDR_W      = 128;
  localparam int V4_W        = 32;

  localparam logic [2:0] REQ_ADD     = 3'd0;
  localparam logic [2:0] REQ_DEL_OLD = 3'd1;
  localparam logic [2:0] REQ_DEL_NEW = 3'd2;
  localparam logic [2:0] REQ_HAS_OLD = 3'd3;
  localparam logic [2:0] REQ_HAS_NEW = 3'd4;
  localparam logic [2:0] REQ_XLATE   = 3'd5;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_DUP      = 2'd1;
  localparam logic [1:0] ST_NOTFOUND = 2'd2;
  localparam logic [1:0] ST_FULL     = 2'd3;

  localparam logic [1:0] CFG_IPV4_EN = 2'd0;
  localparam logic [1:0] CFG_IPV6_EN = 2'd1;

  typedef struct packed {
    logic [2:0]  req_type;
    logic        is_ipv6;
    logic        from_lan;
    logic [63:0] addr_a_hi;
    logic [63:0] addr_a_lo;
    logic [63:0] addr_b_hi;
    logic [63:0] addr_b_lo;
    logic [63:0] uid_hi;
    logic [63:0] uid_lo;
  } in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        found;
    logic        translated;
    logic        rewrite_source;
    logic [63:0] repl_hi;
    logic [63:0] repl_lo;
    logic [63:0] out_uid_hi;
    logic [63:0] out_uid_lo;
  } out_t;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_ADD,
    OP_DEL,
    OP_EXIST,
    OP_XLATE
  } op_t;

  // Classified request handed from the front to the back.
  typedef struct packed {
    op_t               op;
    logic              fam;
    logic              lan;
    logic              chk_old;
    logic              chk_new;
    logic [ADDR_W-1:0] key_old;
    logic [ADDR_W-1:0] key_new;
    logic [ADDR_W-1:0] uid;
  } cmd_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_SCAN,
    B_DONE
  } bstate_t;

endpackage

### sv/dnat_bidirectional_table.sv
// Top level of the destination NAT rule table.
// Each table request (add, delete, exists, translate) scans the whole rule
// memory through its single read port, one entry per cycle, in the back end;
// an ignored request or a translation of a disabled family skips the scan. A
// two-entry queue lets new requests be accepted while the back end scans, and
// the result register holds a finished transaction until it is taken. Add fills
// the lowest free slot; no clearing pass is needed after reset.
module dnat_bidirectional_table import dnatbt_pkg::*; #(
  parameter int ENTRIES = DEF_ENTRIES
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  in_t        in_data,
  output logic       out_valid,
  input  logic       out_stall,
  output out_t       out_data,
  input  logic       cfg_we,
  input  logic [1:0] cfg_idx,
  input  logic       cfg_data
);

  logic ipv4_en, ipv6_en, q_valid, q_pop;
  cmd_t q_cmd;

  always_ff @(posedge clk) begin
    if (rst) begin
      ipv4_en <= 1'b0;
      ipv6_en <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_IPV4_EN: ipv4_en <= cfg_data;
        CFG_IPV6_EN: ipv6_en <= cfg_data;
        default: ;
      endcase
    end
  end

  dnatbt_front u_front (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .ipv4_en(ipv4_en), .ipv6_en(ipv6_en),
    .q_valid(q_valid), .q_cmd(q_cmd), .q_pop(q_pop)
  );

  dnatbt_back #(.ENTRIES(ENTRIES)) u_back (
    .clk(clk), .rst(rst),
    .q_valid(q_valid), .q_cmd(q_cmd), .q_pop(q_pop),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

endmodule

### sv/dnatbt_front.sv
// Front end: accepts requests, normalizes keys, classifies them and queues them.
module dnatbt_front import dnatbt_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  in_t  in_data,
  input  logic ipv4_en,
  input  logic ipv6_en,
  output logic q_valid,
  output cmd_t q_cmd,
  input  logic q_pop
);

  logic [ADDR_W-1:0] a_key, b_key;
  cmd_t cmd_in;
  cmd_t q [2];
  logic [1:0] cnt;
  logic wp, rp, push;

  always_comb begin
    if (in_data.is_ipv6) begin
      a_key = {in_data.addr_a_hi, in_data.addr_a_lo};
      b_key = {in_data.addr_b_hi, in_data.addr_b_lo};
    end else begin
      a_key = {{(ADDR_W-V4_W){1'b0}}, in_data.addr_a_lo[V4_W-1:0]};
      b_key = {{(ADDR_W-V4_W){1'b0}}, in_data.addr_b_lo[V4_W-1:0]};
    end
    cmd_in.op      = OP_NOP;
    cmd_in.fam     = in_data.is_ipv6;
    cmd_in.lan     = in_data.from_lan;
    cmd_in.chk_old = 1'b0;
    cmd_in.chk_new = 1'b0;
    cmd_in.key_old = a_key;
    cmd_in.key_new = b_key;
    cmd_in.uid     = {in_data.uid_hi, in_data.uid_lo};
    case (in_data.req_type)
      REQ_ADD: begin
        cmd_in.op      = OP_ADD;
        cmd_in.chk_old = 1'b1;
        cmd_in.chk_new = 1'b1;
      end
      REQ_DEL_OLD, REQ_HAS_OLD: begin
        cmd_in.op      = (in_data.req_type == REQ_DEL_OLD) ? OP_DEL : OP_EXIST;
        cmd_in.chk_old = 1'b1;
      end
      REQ_DEL_NEW, REQ_HAS_NEW: begin
        cmd_in.op      = (in_data.req_type == REQ_DEL_NEW) ? OP_DEL : OP_EXIST;
        cmd_in.chk_new = 1'b1;
        cmd_in.key_new = a_key;
      end
      REQ_XLATE: begin
        // A disabled family passes through as an empty result.
        if (in_data.is_ipv6 ? ipv6_en : ipv4_en) begin
          cmd_in.op = OP_XLATE;
          if (in_data.from_lan) begin
            cmd_in.chk_new = 1'b1;
            cmd_in.key_new = a_key;
          end else begin
            cmd_in.chk_old = 1'b1;
            cmd_in.key_old = b_key;
          end
        end
      end
      default: cmd_in.op = OP_NOP;
    endcase
  end

  assign in_stall = (cnt == 2'd2);
  assign push     = in_valid && !in_stall;
  assign q_valid  = (cnt != 2'd0);
  assign q_cmd    = q[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
      wp  <= 1'b0;
      rp  <= 1'b0;
    end else begin
      if (push) wp <= ~wp;
      if (q_pop) rp <= ~rp;
      cnt <= cnt + {1'b0, push} - {1'b0, q_pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) q[wp] <= cmd_in;
  end

endmodule

### sv/dnatbt_back.sv
// Back end: rule memory, sequential table scan and the result register.
module dnatbt_back import dnatbt_pkg::*; #(
  parameter int ENTRIES = DEF_ENTRIES
) (
  input  logic clk,
  input  logic rst,
  input  logic q_valid,
  input  cmd_t q_cmd,
  output logic q_pop,
  output logic out_valid,
  input  logic out_stall,
  output out_t out_data
);

  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CW = $clog2(ENTRIES + 1);
  localparam int MW = 1 + 3 * ADDR_W;

  bstate_t state, state_next;
  cmd_t cmd;
  logic [ENTRIES-1:0] valid;
  logic [MW-1:0] mem [ENTRIES];
  logic [MW-1:0] rdata;
  logic [CW-1:0] scan_idx;
  logic [IW-1:0] rd_idx, hit_idx, free_idx;
  logic rd_vld, rd_valid_bit, hit, free_hit;
  logic [ADDR_W-1:0] hit_old, hit_new, hit_uid;
  logic issue, issue_done, load_out, match, start;
  logic r_fam;
  logic [ADDR_W-1:0] r_old, r_new, r_uid;
  out_t res;

  assign issue_done = (scan_idx == CW'(ENTRIES));
  assign {r_fam, r_old, r_new, r_uid} = rdata;
  assign match = rd_vld && rd_valid_bit && (r_fam == cmd.fam) &&
                 ((cmd.chk_old && (r_old == cmd.key_old)) ||
                  (cmd.chk_new && (r_new == cmd.key_new)));

  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    start      = 1'b0;
    issue      = 1'b0;
    load_out   = 1'b0;
    case (state)
      B_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          start = 1'b1;
          state_next = (q_cmd.op == OP_NOP) ? B_DONE : B_SCAN;
        end
      end
      B_SCAN: begin
        issue = !issue_done;
        if (issue_done && rd_vld) state_next = B_DONE;
      end
      B_DONE: begin
        if (!out_valid || !out_stall) begin
          load_out   = 1'b1;
          state_next = B_IDLE;
        end
      end
      default: state_next = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= B_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    res = '0;
    case (cmd.op)
      OP_ADD: res.status = hit ? ST_DUP : (free_hit ? ST_OK : ST_FULL);
      OP_DEL, OP_EXIST: begin
        res.status = hit ? ST_OK : ST_NOTFOUND;
        res.found  = hit;
      end
      OP_XLATE: begin
        if (hit) begin
          res.found          = 1'b1;
          res.translated     = 1'b1;
          res.rewrite_source = cmd.lan;
          {res.repl_hi, res.repl_lo}       = cmd.lan ? hit_old : hit_new;
          {res.out_uid_hi, res.out_uid_lo} = hit_uid;
        end else begin
          res.status = ST_NOTFOUND;
        end
      end
      default: res = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid     <= '0;
      out_valid <= 1'b0;
      rd_vld    <= 1'b0;
    end else begin
      rd_vld <= issue;
      if (issue) rd_valid_bit <= valid[scan_idx[IW-1:0]];
      if (load_out) begin
        out_valid <= 1'b1;
        if (cmd.op == OP_ADD && !hit && free_hit) valid[free_idx] <= 1'b1;
        if (cmd.op == OP_DEL && hit) valid[hit_idx] <= 1'b0;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      cmd      <= q_cmd;
      scan_idx <= '0;
      hit      <= 1'b0;
      free_hit <= 1'b0;
    end else begin
      if (issue) begin
        scan_idx <= scan_idx + CW'(1);
        rd_idx   <= scan_idx[IW-1:0];
      end
      if (match && !hit) begin
        hit     <= 1'b1;
        hit_idx <= rd_idx;
        hit_old <= r_old;
        hit_new <= r_new;
        hit_uid <= r_uid;
      end
      if (rd_vld && !rd_valid_bit && !free_hit) begin
        free_hit <= 1'b1;
        free_idx <= rd_idx;
      end
    end
    if (load_out) out_data <= res;
  end

  // Rule memory: one write port for adds, one registered read port for the scan.
  always_ff @(posedge clk) begin
    if (load_out && cmd.op == OP_ADD && !hit && free_hit)
      mem[free_idx] <= {cmd.fam, cmd.key_old, cmd.key_new, cmd.uid};
    if (issue) rdata <= mem[scan_idx[IW-1:0]];
  end

endmodule

### sv/dnatbt_checker.sv
// Port-level checks for the destination NAT rule table.
module dnatbt_props import dnatbt_pkg::*; (
  input logic clk,
  input logic rst,
  input logic out_valid,
  input logic out_stall,
  input out_t out_data
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  a_xlate_found: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.translated |-> out_data.found && out_data.status == ST_OK)
    else $error("translation without a match");

  a_miss_empty: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.translated |->
      !out_data.rewrite_source && out_data.repl_hi == '0 && out_data.repl_lo == '0 &&
      out_data.out_uid_hi == '0 && out_data.out_uid_lo == '0)
    else $error("payload set without a translation");

  a_found_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.found |-> out_data.status == ST_OK)
    else $error("match reported with an error status");

endmodule

bind dnat_bidirectional_table dnatbt_props u_chk (
  .clk(clk), .rst(rst),
  .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
);

### dv/dnatbt_checker.sv
// Scoreboard for the destination NAT rule table: predicts each request and checks each result.
`timescale 1ns / 100ps
module dnatbt_checker import dnatbt_pkg::*; #(
  parameter int ENTRIES = DEF_ENTRIES
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  input  logic in_stall,
  input  in_t  in_data,
  input  logic out_valid,
  input  logic out_stall,
  input  out_t out_data,
  input  logic cfg_we,
  input  logic [1:0] cfg_idx,
  input  logic cfg_data,
  output int   pending,
  output int   errors
);

  logic              v4_on, v6_on;
  logic              rule_used [ENTRIES];
  logic              rule_v6   [ENTRIES];
  logic [ADDR_W-1:0] rule_old  [ENTRIES];
  logic [ADDR_W-1:0] rule_new  [ENTRIES];
  logic [ADDR_W-1:0] rule_uid  [ENTRIES];
  out_t              awaited_results [$];

  assign pending = awaited_results.size();

  // Returns the slot holding the key on the chosen side (new when by_new), or -1.
  function automatic int find_rule(logic by_new, logic v6, logic [ADDR_W-1:0] key);
    for (int i = 0; i < ENTRIES; i++) begin
      if (rule_used[i] && rule_v6[i] == v6 &&
          (by_new ? rule_new[i] : rule_old[i]) == key) return i;
    end
    return -1;
  endfunction

  function automatic out_t apply_request(in_t rq);
    out_t              res;
    logic [ADDR_W-1:0] a, b;
    int                k;
    res = '0;
    a = {rq.addr_a_hi, rq.addr_a_lo};
    b = {rq.addr_b_hi, rq.addr_b_lo};
    if (!rq.is_ipv6) begin
      a = {96'd0, a[V4_W-1:0]};
      b = {96'd0, b[V4_W-1:0]};
    end
    case (rq.req_type)
      REQ_ADD: begin
        if (find_rule(1'b0, rq.is_ipv6, a) >= 0 || find_rule(1'b1, rq.is_ipv6, b) >= 0) begin
          res.status = ST_DUP;
        end else begin
          k = -1;
          for (int i = 0; i < ENTRIES; i++) begin
            if (!rule_used[i] && k < 0) k = i;
          end
          if (k < 0) begin
            res.status = ST_FULL;
          end else begin
            rule_used[k] = 1'b1;
            rule_v6[k]   = rq.is_ipv6;
            rule_old[k]  = a;
            rule_new[k]  = b;
            rule_uid[k]  = {rq.uid_hi, rq.uid_lo};
          end
        end
      end
      REQ_DEL_OLD, REQ_DEL_NEW, REQ_HAS_OLD, REQ_HAS_NEW: begin
        k = find_rule(rq.req_type == REQ_DEL_NEW || rq.req_type == REQ_HAS_NEW,
                      rq.is_ipv6, a);
        if (k < 0) begin
          res.status = ST_NOTFOUND;
        end else begin
          res.found = 1'b1;
          if (rq.req_type == REQ_DEL_OLD || rq.req_type == REQ_DEL_NEW) rule_used[k] = 1'b0;
        end
      end
      REQ_XLATE: begin
        if (rq.is_ipv6 ? v6_on : v4_on) begin
          // LAN traffic maps its source back to the old address.
          k = rq.from_lan ? find_rule(1'b1, rq.is_ipv6, a) : find_rule(1'b0, rq.is_ipv6, b);
          if (k < 0) begin
            res.status = ST_NOTFOUND;
          end else begin
            res.found = 1'b1;
            res.translated = 1'b1;
            res.rewrite_source = rq.from_lan;
            {res.repl_hi, res.repl_lo} = rq.from_lan ? rule_old[k] : rule_new[k];
            {res.out_uid_hi, res.out_uid_lo} = rule_uid[k];
          end
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  task automatic field_check(string name, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    out_t want;
    if (rst) begin
      v4_on <= 1'b0;
      v6_on <= 1'b0;
      for (int i = 0; i < ENTRIES; i++) rule_used[i] = 1'b0;
      awaited_results.delete();
      errors = 0;
    end else begin
      if (cfg_we) begin
        if (cfg_idx == CFG_IPV4_EN) v4_on <= cfg_data;
        else if (cfg_idx == CFG_IPV6_EN) v6_on <= cfg_data;
      end
      if (out_valid && !out_stall) begin
        if (awaited_results.size() == 0) begin
          $display("%0t: unexpected result transaction, expected none, actual %h",
                   $time, out_data);
          errors++;
        end else begin
          want = awaited_results.pop_front();
          field_check("status", 64'(want.status), 64'(out_data.status));
          field_check("found", 64'(want.found), 64'(out_data.found));
          field_check("translated", 64'(want.translated), 64'(out_data.translated));
          field_check("rewrite_source", 64'(want.rewrite_source),
                      64'(out_data.rewrite_source));
          field_check("repl_hi", want.repl_hi, out_data.repl_hi);
          field_check("repl_lo", want.repl_lo, out_data.repl_lo);
          field_check("out_uid_hi", want.out_uid_hi, out_data.out_uid_hi);
          field_check("out_uid_lo", want.out_uid_lo, out_data.out_uid_lo);
        end
      end
      if (in_valid && !in_stall) awaited_results.push_back(apply_request(in_data));
    end
  end

endmodule

### dv/testbench.sv
// Stimulus and verdict for the destination NAT rule table.
`timescale 1ns / 100ps
module testbench;
  import dnatbt_pkg::*;

  localparam logic [1:0] CFG_SPARE = 2'd2;
  localparam int POOL = 96;
  localparam int CYCLE_LIMIT = 3000000;

  logic       clk, rst;
  logic       in_valid, in_stall, out_valid, out_stall;
  in_t        in_data;
  out_t       out_data;
  logic       cfg_we;
  logic [1:0] cfg_idx;
  logic       cfg_data;
  int         pending, errors;
  int         cycles;
  bit         idling_on;
  int         stall_left;
  logic [ADDR_W-1:0] addr_pool [POOL];

  dnat_bidirectional_table uut (.*);
  dnatbt_checker u_check (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Receiver backpressure in random bursts.
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall  <= 1'b1;
    end else if (idling_on && $urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 12);
      out_stall  <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  function automatic logic [ADDR_W-1:0] rand_addr();
    return {$urandom, $urandom, $urandom, $urandom};
  endfunction

  // Pool address; for IPv4 the ignored upper bits get random noise.
  function automatic logic [ADDR_W-1:0] pool_addr(logic v6);
    logic [ADDR_W-1:0] p;
    logic [ADDR_W-1:0] noise;
    p = ($urandom_range(0, 15) == 0) ? rand_addr() : addr_pool[$urandom_range(0, POOL - 1)];
    noise = rand_addr();
    if (!v6) p = {noise[ADDR_W-1:V4_W], p[V4_W-1:0]};
    return p;
  endfunction

  function automatic in_t make_request(logic [2:0] kind, logic v6, logic lan,
                                       logic [ADDR_W-1:0] a, logic [ADDR_W-1:0] b);
    in_t rq;
    rq.req_type = kind;
    rq.is_ipv6  = v6;
    rq.from_lan = lan;
    {rq.addr_a_hi, rq.addr_a_lo} = a;
    {rq.addr_b_hi, rq.addr_b_lo} = b;
    {rq.uid_hi, rq.uid_lo} = rand_addr();
    return rq;
  endfunction

  task automatic send(in_t rq);
    in_data  <= rq;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    if (idling_on && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic val);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic random_phase(int count, int add_weight);
    logic [2:0] kind;
    logic       v6;
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(0, 99) < add_weight) kind = REQ_ADD;
      else if ($urandom_range(0, 29) == 0) kind = 3'($urandom_range(6, 7));
      else kind = 3'($urandom_range(REQ_DEL_OLD, REQ_XLATE));
      v6 = 1'($urandom_range(0, 1));
      send(make_request(kind, v6, 1'($urandom_range(0, 1)), pool_addr(v6), pool_addr(v6)));
    end
  endtask

  initial begin
    logic [ADDR_W-1:0] o4, n4, o6, n6, ones;
    cycles = 0;
    stall_left = 0;
    idling_on = 1'b1;
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    out_stall = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = CFG_IPV4_EN;
    cfg_data = 1'b0;
    for (int i = 0; i < POOL; i++) addr_pool[i] = rand_addr();
    ones = '1;
    o4 = {96'd0, 32'hffffffff};
    n4 = {64'hdeadbeef_00000000, 64'h0};
    o6 = ones;
    n6 = '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: extremes, duplicates, families kept apart, misses, ignored types.
    send(make_request(REQ_ADD, 1'b0, 1'b0, o4, n4));
    send(make_request(REQ_ADD, 1'b1, 1'b0, o6, n6));
    send(make_request(REQ_ADD, 1'b0, 1'b0, ones, addr_pool[0]));
    send(make_request(REQ_ADD, 1'b1, 1'b0, addr_pool[1], n6));
    send(make_request(REQ_ADD, 1'b1, 1'b0, o4, n4));
    send(make_request(REQ_HAS_OLD, 1'b0, 1'b0, ones, '0));
    send(make_request(REQ_HAS_NEW, 1'b0, 1'b0, n4, '0));
    send(make_request(REQ_HAS_NEW, 1'b1, 1'b0, addr_pool[2], '0));
    send(make_request(REQ_XLATE, 1'b0, 1'b0, '0, o4));
    send(make_request(REQ_XLATE, 1'b1, 1'b1, n6, '0));
    send(make_request(3'd6, 1'b1, 1'b1, ones, ones));
    send(make_request(3'd7, 1'b0, 1'b0, '0, '0));
    drain();
    write_reg(CFG_IPV4_EN, 1'b1);
    write_reg(CFG_IPV6_EN, 1'b1);
    write_reg(CFG_SPARE, 1'b0);
    send(make_request(REQ_XLATE, 1'b0, 1'b0, ones, o4));
    send(make_request(REQ_XLATE, 1'b0, 1'b1, n4, '0));
    send(make_request(REQ_XLATE, 1'b1, 1'b0, '0, o6));
    send(make_request(REQ_XLATE, 1'b1, 1'b1, n6, ones));
    send(make_request(REQ_XLATE, 1'b1, 1'b0, '0, addr_pool[3]));
    send(make_request(REQ_DEL_OLD, 1'b0, 1'b0, o4, '0));
    send(make_request(REQ_DEL_NEW, 1'b1, 1'b0, n6, '0));
    send(make_request(REQ_DEL_NEW, 1'b1, 1'b0, n6, '0));
    send(make_request(REQ_XLATE, 1'b0, 1'b0, '0, o4));
    drain();

    // Random phases; the add-heavy ones fill the table to the full case.
    for (int ph = 0; ph < 8; ph++) begin
      write_reg(CFG_IPV4_EN, ph[0]);
      write_reg(CFG_IPV6_EN, ph[1]);
      if (ph == 7) idling_on = 1'b0;
      random_phase(215, (ph % 3 == 0) ? 75 : 25);
      drain();
    end

    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
